// ===== rtl/core/lbs_pkg.sv =====
`default_nettype none

package lbs_pkg;

	// Default build of the bin row.
	localparam int NUM_BINS_DEF  = 64;
	localparam int LOAD_BITS_DEF = 16;

	// Width of bin numbers on the ports and of the bins_in_use register.
	localparam int BIN_W = 7;

	// Value of bins_in_use after reset.
	localparam logic [BIN_W-1:0] BINS_IN_USE_RST = 7'd64;

endpackage

`default_nettype wire

// ===== rtl/core/lbs_cell.sv =====
`default_nettype none

module lbs_cell #(
	parameter int LOAD_BITS = 16,
	parameter int IDX_W     = 6,
	parameter int INDEX     = 0
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  [lbs_pkg::BIN_W-1:0]   act_n,
	input  wire                         prev_vld,
	input  wire  [LOAD_BITS-1:0]        prev_load,
	input  wire  [IDX_W-1:0]            prev_idx,
	output logic                        next_vld,
	output logic [LOAD_BITS-1:0]        next_load,
	output logic [IDX_W-1:0]            next_idx,
	input  wire                         inc_en,
	input  wire  [IDX_W-1:0]            inc_idx
);
	import lbs_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [LOAD_BITS-1:0] load_q;
	logic                 next_vld_q;
	logic [LOAD_BITS-1:0] next_load_q;
	logic [IDX_W-1:0]     next_idx_q;
	logic                 active;
	logic                 take;

	// A bin beyond the number in use only passes the candidate along.
	assign active = (INDEX < (1 << BIN_W)) && (BIN_W'(INDEX) < act_n);
	// Strictly smaller wins, so the lowest index keeps a tie.
	assign take   = active && (load_q < prev_load);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q     <= '0;
			next_vld_q <= 1'b0;
		end else begin
			next_vld_q <= prev_vld;
			if (inc_en && (inc_idx == MY_IDX) && (load_q != {LOAD_BITS{1'b1}})) begin
				load_q <= load_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prev_vld) begin
			next_load_q <= take ? load_q : prev_load;
			next_idx_q  <= take ? MY_IDX : prev_idx;
		end
	end

	assign next_vld  = next_vld_q;
	assign next_load = next_load_q;
	assign next_idx  = next_idx_q;

endmodule

`default_nettype wire

// ===== rtl/core/least_loaded_bin_selector.sv =====
// Least loaded bin selector.
//
// Each word on the request channel (in_valid, in_ready, request_bin) names a
// bin from 1 to bins_in_use, or asks with 0 for the bin with the smallest
// load count, the lowest bin number winning a tie. The chosen bin's count is
// incremented, saturating at its maximum, and one word leaves on the result
// channel (out_valid, out_ready, chosen_bin, rejected). A request above the
// number of bins in use gives chosen_bin 0 with rejected set and leaves all
// counts unchanged. The user writes bins_in_use via cfg_we/cfg_wdata only while the
// block is idle, unchecked by the block; 0 acts as 1, over NUM_BINS as NUM_BINS.
//
// The counts live in a row of NUM_BINS cells. An automatic choice sends a
// candidate down the row, one cell per cycle, and the chosen bin enters a
// decision register; a named or rejected request goes there directly. The
// decision then moves to the output register, and the next request is taken
// while it waits there. If the receiver stalls with a result still held,
// the next decision waits until the output register frees up.
// Reset clears all counts at once, sets bins_in_use to 64 and empties the
// output register.
`default_nettype none

module least_loaded_bin_selector #(
	parameter int NUM_BINS  = lbs_pkg::NUM_BINS_DEF,
	parameter int LOAD_BITS = lbs_pkg::LOAD_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire  [lbs_pkg::BIN_W-1:0]  cfg_wdata,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire  [lbs_pkg::BIN_W-1:0]  request_bin,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [lbs_pkg::BIN_W-1:0]  chosen_bin,
	output logic                       rejected
);
	import lbs_pkg::*;

	localparam int IDX_W = $clog2(NUM_BINS);

	// Controller states.
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SWEEP = 2'd1;
	localparam logic [1:0] S_PUSH  = 2'd2;

	logic [1:0]       state_q;
	logic [BIN_W-1:0] bins_in_use_q;
	logic [BIN_W-1:0] act_n;

	// Decision held until the output register can take it.
	logic             rej_q;
	logic [BIN_W-1:0] pick_q;
	logic [IDX_W-1:0] inc_idx_q;

	logic             out_vld_q;
	logic [BIN_W-1:0] out_bin_q;
	logic             out_rej_q;

	logic             accept;
	logic             push;
	logic             inc_en;
	logic [BIN_W-1:0] req_m1;

	// Candidate path through the cell row.
	logic                 tok_vld  [NUM_BINS+1];
	logic [LOAD_BITS-1:0] tok_load [NUM_BINS+1];
	logic [IDX_W-1:0]     tok_idx  [NUM_BINS+1];

	always_comb begin
		act_n = bins_in_use_q;
		if (bins_in_use_q == '0) begin
			act_n = BIN_W'(1);
		end else if (32'(bins_in_use_q) > NUM_BINS) begin
			act_n = BIN_W'(NUM_BINS);
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign push     = (state_q == S_PUSH) && (!out_vld_q || out_ready);
	// The count moves at the same edge that the result enters the output register.
	assign inc_en   = push && !rej_q;
	assign req_m1   = request_bin - 1'b1;

	// The candidate enters the first cell with the largest load, so the
	// first bin always replaces it unless it is saturated too.
	assign tok_vld[0]  = accept && (request_bin == '0);
	assign tok_load[0] = {LOAD_BITS{1'b1}};
	assign tok_idx[0]  = '0;

	for (genvar k = 0; k < NUM_BINS; k++) begin : g_cell
		lbs_cell #(
			.LOAD_BITS (LOAD_BITS),
			.IDX_W     (IDX_W),
			.INDEX     (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.act_n     (act_n),
			.prev_vld  (tok_vld[k]),
			.prev_load (tok_load[k]),
			.prev_idx  (tok_idx[k]),
			.next_vld  (tok_vld[k+1]),
			.next_load (tok_load[k+1]),
			.next_idx  (tok_idx[k+1]),
			.inc_en    (inc_en),
			.inc_idx   (inc_idx_q)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_in_use_q <= BINS_IN_USE_RST;
		end else if (cfg_we) begin
			bins_in_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (request_bin == '0) ? S_SWEEP : S_PUSH;
					end
				end
				S_SWEEP: begin
					if (tok_vld[NUM_BINS]) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (push) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rej_q     <= (request_bin > act_n);
			pick_q    <= (request_bin > act_n) ? '0 : request_bin;
			inc_idx_q <= IDX_W'(req_m1);
		end else if ((state_q == S_SWEEP) && tok_vld[NUM_BINS]) begin
			rej_q     <= 1'b0;
			pick_q    <= BIN_W'(tok_idx[NUM_BINS]) + 1'b1;
			inc_idx_q <= tok_idx[NUM_BINS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_bin_q <= pick_q;
			out_rej_q <= rej_q;
		end
	end

	assign out_valid  = out_vld_q;
	assign chosen_bin = out_bin_q;
	assign rejected   = out_rej_q;

endmodule

`default_nettype wire

// ===== rtl/core/lbs_checker.sv =====
`default_nettype none

module lbs_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       in_valid,
	input wire                       in_ready,
	input wire                       out_valid,
	input wire                       out_ready,
	input wire [lbs_pkg::BIN_W-1:0]  chosen_bin,
	input wire                       rejected
);
	import lbs_pkg::*;

	// A held result must not change while the receiver stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chosen_bin) && $stable(rejected))
		else $error("result word changed while stalled");

	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> chosen_bin == '0)
		else $error("rejected word carries a bin number");

	a_pick_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rejected |-> chosen_bin != '0)
		else $error("accepted word carries bin zero");

	// Only one request is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

endmodule

bind least_loaded_bin_selector lbs_checker u_lbs_checker (.*);

`default_nettype wire
